// ===== design/mpwd_pkg.sv =====
// Package for the Morse pulse-width decoder.
// Holds the run kinds, the queue entry type and the shared constants.
// No dependencies.
`timescale 1ns / 1ps

package mpwd_pkg;

	localparam int TIME_BITS_DEF        = 32;
	localparam int END_MARKS_NEEDED_DEF = 3;
	localparam int QUEUE_DEPTH_DEF      = 2;

	localparam int EDGE_TIME_W = 32;
	localparam int UNIT_W      = 20;
	localparam int THR4_W      = UNIT_W + 2;
	localparam int RUN_IDX_W   = 3;

	localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(10000);

	typedef enum logic [1:0] {
		RUN_SHORT = 2'b00,
		RUN_LONG  = 2'b01,
		RUN_END   = 2'b10
	} run_kind_t;

	typedef struct packed {
		run_kind_t kind;
		logic      done;
	} run_entry_t;

	function automatic logic [RUN_IDX_W-1:0] run_last_idx(input run_kind_t kind);
		logic [RUN_IDX_W-1:0] idx;
		case (kind)
			RUN_END:   idx = RUN_IDX_W'(4);
			RUN_LONG:  idx = RUN_IDX_W'(3);
			RUN_SHORT: idx = RUN_IDX_W'(1);
			default:   idx = RUN_IDX_W'(1);
		endcase
		return idx;
	endfunction

endpackage

// ===== design/mpwd_front.sv =====
// Front end of the Morse pulse-width decoder: edge capture, pulse timing,
// classification and end-mark counting. Pushes one run entry per pulse longer than one unit.
// Depends on mpwd_pkg.
`timescale 1ns / 1ps

module mpwd_front #(
	parameter int TIME_BITS        = mpwd_pkg::TIME_BITS_DEF,
	parameter int END_MARKS_NEEDED = mpwd_pkg::END_MARKS_NEEDED_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic                               pin_level,
	input  logic [mpwd_pkg::EDGE_TIME_W-1:0]   edge_time_us,
	input  logic                               cfg_we,
	input  logic [mpwd_pkg::UNIT_W-1:0]        cfg_wdata,
	input  logic                               q_full,
	output logic                               q_push,
	output mpwd_pkg::run_entry_t               q_entry
);

	localparam int WIDE_W = (TIME_BITS > mpwd_pkg::EDGE_TIME_W) ? TIME_BITS
		: mpwd_pkg::EDGE_TIME_W;
	localparam int CMP_W  = (TIME_BITS > mpwd_pkg::THR4_W) ? TIME_BITS : mpwd_pkg::THR4_W;
	localparam int CNT_W  = $clog2(END_MARKS_NEEDED + 1);

	logic [mpwd_pkg::UNIT_W-1:0] unit_q;
	logic                        armed_q;
	logic [TIME_BITS-1:0]        start_q;
	logic [CNT_W-1:0]            count_q;
	logic                        done_q;

	logic                  accept;
	logic [WIDE_W-1:0]     time_wide;
	logic [TIME_BITS-1:0]  time_now;
	logic [TIME_BITS-1:0]  elapsed;
	logic [CMP_W-1:0]      elapsed_c;
	logic [CMP_W-1:0]      thr4, thr2, thr1;
	logic                  measure;
	logic                  over4, over2, over1;
	logic [CNT_W-1:0]      count_next;
	logic                  done_next;

	assign accept    = push && !q_full;
	assign time_wide = WIDE_W'(edge_time_us);
	assign time_now  = time_wide[TIME_BITS-1:0];
	assign elapsed   = time_now - start_q;
	assign elapsed_c = CMP_W'(elapsed);
	assign thr1      = CMP_W'(unit_q);
	assign thr2      = CMP_W'({unit_q, 1'b0});
	assign thr4      = CMP_W'({unit_q, 2'b00});
	assign over4     = elapsed_c > thr4;
	assign over2     = elapsed_c > thr2;
	assign over1     = elapsed_c > thr1;
	assign measure   = accept && pin_level && armed_q;

	always_comb begin
		count_next = count_q;
		if (over4) begin
			if (count_q < CNT_W'(END_MARKS_NEEDED)) begin
				count_next = count_q + CNT_W'(1);
			end
		end else if (over1) begin
			count_next = '0;
		end
		done_next = done_q || (over4 && (count_next >= CNT_W'(END_MARKS_NEEDED)));
	end

	always_comb begin
		q_push       = measure && over1;
		q_entry.done = done_next;
		if (over4) begin
			q_entry.kind = mpwd_pkg::RUN_END;
		end else if (over2) begin
			q_entry.kind = mpwd_pkg::RUN_LONG;
		end else begin
			q_entry.kind = mpwd_pkg::RUN_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q  <= mpwd_pkg::UNIT_RESET;
			armed_q <= 1'b0;
			start_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unit_q <= cfg_wdata;
			end
			if (accept && !pin_level) begin
				armed_q <= 1'b1;
				start_q <= time_now;
			end else if (measure) begin
				armed_q <= 1'b0;
				count_q <= count_next;
				done_q  <= done_next;
			end
		end
	end

endmodule

// ===== design/mpwd_queue.sv =====
// Small queue of run entries between the front and back ends of the decoder.
// Register-based storage with read and write pointers. Depends on mpwd_pkg.
`timescale 1ns / 1ps

module mpwd_queue #(
	parameter int QUEUE_DEPTH = mpwd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  mpwd_pkg::run_entry_t wr_entry,
	input  logic                 rd_en,
	output mpwd_pkg::run_entry_t rd_entry,
	output logic                 full,
	output logic                 empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	mpwd_pkg::run_entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/mpwd_back.sv =====
// Back end of the Morse pulse-width decoder: expands each run entry into its
// bits into an output register, one per cycle while the register is empty or popped. Depends on mpwd_pkg.
`timescale 1ns / 1ps

module mpwd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpwd_pkg::run_entry_t q_entry,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic                 bit_value,
	output logic                 run_last,
	output logic                 message_complete
);

	logic [mpwd_pkg::RUN_IDX_W-1:0] idx_q;
	logic                           out_valid_q;
	logic                           bit_q;
	logic                           last_q;
	logic                           done_q;

	logic [mpwd_pkg::RUN_IDX_W-1:0] last_idx;
	logic                           out_ready;
	logic                           fire;
	logic                           is_last;

	assign last_idx  = mpwd_pkg::run_last_idx(q_entry.kind);
	assign is_last   = idx_q == last_idx;
	assign out_ready = !out_valid_q || pop;
	assign fire      = !q_empty && out_ready;
	assign q_pop     = fire && is_last;

	assign empty            = !out_valid_q;
	assign bit_value        = bit_q;
	assign run_last         = last_q;
	assign message_complete = done_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			bit_q  <= !is_last;
			last_q <= is_last;
			done_q <= q_entry.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + mpwd_pkg::RUN_IDX_W'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/morse_pulse_width_decoder_top.sv =====
// Top level of the Morse pulse-width decoder: front end, run queue, back end.
// Depends on mpwd_pkg, mpwd_front, mpwd_queue and mpwd_back.
//
//   Channel   Direction  Handshake            Payload
//   edges     in         push / full          pin_level, edge_time_us
//   bits      out        pop / empty          bit_value, run_last, message_complete
//   config    in         cfg_we               cfg_wdata (unit period, us)
//
// An edge is classified in the cycle of its transfer; a pulse longer than one unit queues a run.
// The back end emits one bit per cycle while pop keeps up; a run has two, four or five bits.
// Reset clears the control state and loads a unit period of 10000 us.
// Full rises only when the run queue is full; a valid output register holds while pop is low.
`timescale 1ns / 1ps

module morse_pulse_width_decoder_top #(
	parameter int TIME_BITS        = mpwd_pkg::TIME_BITS_DEF,
	parameter int END_MARKS_NEEDED = mpwd_pkg::END_MARKS_NEEDED_DEF,
	parameter int QUEUE_DEPTH      = mpwd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              pin_level,
	input  logic [mpwd_pkg::EDGE_TIME_W-1:0]  edge_time_us,
	input  logic                              cfg_we,
	input  logic [mpwd_pkg::UNIT_W-1:0]       cfg_wdata,
	output logic                              empty,
	input  logic                              pop,
	output logic                              bit_value,
	output logic                              run_last,
	output logic                              message_complete
);

	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;
	mpwd_pkg::run_entry_t wr_entry;
	mpwd_pkg::run_entry_t rd_entry;

	assign full = q_full;

	mpwd_front #(
		.TIME_BITS        (TIME_BITS),
		.END_MARKS_NEEDED (END_MARKS_NEEDED)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.pin_level    (pin_level),
		.edge_time_us (edge_time_us),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (wr_entry)
	);

	mpwd_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (wr_entry),
		.rd_en    (q_pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	mpwd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_entry          (rd_entry),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.pop              (pop),
		.empty            (empty),
		.bit_value        (bit_value),
		.run_last         (run_last),
		.message_complete (message_complete)
	);

endmodule

// ===== sim/mpwd_bit_checker.sv =====
// Checker for the Morse pulse-width decoder: predicts the bit runs from the edge transfers.
// It compares every bit transfer with the oldest prediction and reports errors and pending bits.
// Depends on mpwd_pkg.
`timescale 1ns / 1ps

module mpwd_bit_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             full,
	input  logic                             pin_level,
	input  logic [mpwd_pkg::EDGE_TIME_W-1:0] edge_time_us,
	input  logic                             cfg_we,
	input  logic [mpwd_pkg::UNIT_W-1:0]      cfg_wdata,
	input  logic                             empty,
	input  logic                             pop,
	input  logic                             bit_value,
	input  logic                             run_last,
	input  logic                             message_complete,
	output int                               errors,
	output int                               pending
);

	typedef struct packed {
		logic bit_value;
		logic run_last;
		logic message_complete;
	} decoded_bit_t;

	decoded_bit_t predicted_bits[$];

	logic [mpwd_pkg::UNIT_W-1:0]      unit_us;
	logic                             armed;
	logic [mpwd_pkg::EDGE_TIME_W-1:0] pulse_start;
	int                               end_marks;
	logic                             msg_done;

	task automatic predict_edge(input logic lvl, input logic [mpwd_pkg::EDGE_TIME_W-1:0] stamp);
		logic [mpwd_pkg::EDGE_TIME_W-1:0] span;
		logic [63:0]                      unit64;
		int                               run_len;
		run_len = 0;
		unit64 = 64'(unit_us);
		if (!lvl) begin
			armed = 1'b1;
			pulse_start = stamp;
		end else if (armed) begin
			armed = 1'b0;
			span = stamp - pulse_start;
			if (64'(span) > unit64 * 64'd4) begin
				run_len = 5;
				if (end_marks < mpwd_pkg::END_MARKS_NEEDED_DEF)
					end_marks++;
				if (end_marks >= mpwd_pkg::END_MARKS_NEEDED_DEF)
					msg_done = 1'b1;
			end else if (64'(span) > unit64 * 64'd2) begin
				run_len = 4;
				end_marks = 0;
			end else if (64'(span) > unit64) begin
				run_len = 2;
				end_marks = 0;
			end
			for (int k = 0; k < run_len; k++)
				predicted_bits.push_back('{bit_value: (k != run_len - 1),
					run_last: (k == run_len - 1), message_complete: msg_done});
		end
	endtask

	task automatic check_bit();
		decoded_bit_t want;
		if (predicted_bits.size() == 0) begin
			if (errors < 10)
				$display("unexpected bit transfer: bit %b last %b complete %b",
					bit_value, run_last, message_complete);
			errors++;
		end else begin
			want = predicted_bits.pop_front();
			if (want.bit_value !== bit_value || want.run_last !== run_last ||
					want.message_complete !== message_complete) begin
				if (errors < 10)
					$display("bit mismatch: expected bit %b last %b complete %b, got %b %b %b",
						want.bit_value, want.run_last, want.message_complete,
						bit_value, run_last, message_complete);
				errors++;
			end
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_us = mpwd_pkg::UNIT_RESET;
			armed = 1'b0;
			pulse_start = '0;
			end_marks = 0;
			msg_done = 1'b0;
			predicted_bits.delete();
		end else begin
			if (pop && !empty)
				check_bit();
			if (cfg_we)
				unit_us = cfg_wdata;
			if (push && !full)
				predict_edge(pin_level, edge_time_us);
		end
		pending = predicted_bits.size();
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the Morse pulse-width decoder: clock, reset, edge and pop stimulus, verdict.
// Depends on mpwd_pkg, morse_pulse_width_decoder_top and mpwd_bit_checker.
`timescale 1ns / 1ps

module tb;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 48;
	localparam int SETTLE_CYCLES = 12;

	logic                             clk;
	logic                             arst_n;
	logic                             push;
	logic                             full;
	logic                             pin_level;
	logic [mpwd_pkg::EDGE_TIME_W-1:0] edge_time_us;
	logic                             cfg_we;
	logic [mpwd_pkg::UNIT_W-1:0]      cfg_wdata;
	logic                             empty;
	logic                             pop;
	logic                             bit_value;
	logic                             run_last;
	logic                             message_complete;
	int                               errors;
	int                               pending;
	logic                             calm;
	logic [mpwd_pkg::UNIT_W-1:0]      cur_unit;

	morse_pulse_width_decoder_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.pin_level        (pin_level),
		.edge_time_us     (edge_time_us),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.empty            (empty),
		.pop              (pop),
		.bit_value        (bit_value),
		.run_last         (run_last),
		.message_complete (message_complete)
	);

	mpwd_bit_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.pin_level        (pin_level),
		.edge_time_us     (edge_time_us),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.empty            (empty),
		.pop              (pop),
		.bit_value        (bit_value),
		.run_last         (run_last),
		.message_complete (message_complete),
		.errors           (errors),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_edge(input logic lvl, input logic [mpwd_pkg::EDGE_TIME_W-1:0] stamp);
		while (!calm && $urandom_range(99) < 6) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		pin_level <= lvl;
		edge_time_us <= stamp;
		do @(posedge clk); while (full);
	endtask

	task automatic send_pulse(input logic [mpwd_pkg::EDGE_TIME_W-1:0] start,
			input logic [31:0] len);
		send_edge(1'b0, start);
		send_edge(1'b1, start + len);
	endtask

	// Waits for every predicted bit, then lets an edge without a run finish.
	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_unit(input logic [mpwd_pkg::UNIT_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cur_unit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_len(input logic [mpwd_pkg::UNIT_W-1:0] u);
		logic [31:0] base;
		base = 32'(u) << $urandom_range(2);
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'd0;
			2: return $urandom_range(5 * int'(u));
			default: return base + $urandom_range(4) - 32'd2;
		endcase
	endfunction

	initial begin
		int count;
		int roll;
		logic [mpwd_pkg::UNIT_W-1:0] phase_units[7];
		phase_units = '{20'd1, 20'd0, 20'hFFFFF, 20'd1000000, 20'd10000, 20'd1, 20'd1};
		phase_units[5] = mpwd_pkg::UNIT_W'($urandom_range(1000000, 1));
		phase_units[6] = mpwd_pkg::UNIT_W'($urandom_range(64, 2));
		arst_n = 1'b0;
		push = 1'b0;
		pin_level = 1'b0;
		edge_time_us = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		cur_unit = mpwd_pkg::UNIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset unit period of 10000 us.
		send_edge(1'b1, 32'd5);
		send_pulse(32'hFFFF_FF00, 32'd40001);
		send_pulse(32'd100, 32'd40000);
		send_pulse(32'd0, 32'd20000);
		send_pulse(32'd7, 32'd10000);
		send_pulse(32'd0, 32'd10001);
		send_pulse(32'd0, 32'd20001);
		send_edge(1'b0, 32'd0);
		send_pulse(32'd1000, 32'hFFFF_FFFF);
		send_pulse(32'hA5A5_5A5A, 32'd0);
		send_pulse(32'h5A5A_A5A5, 32'd50000);
		send_pulse(32'h1234_5678, 32'd90000);
		send_pulse(32'hFFFF_FFFF, 32'd40001);
		send_pulse(32'h8000_0000, 32'd15000);

		foreach (phase_units[p]) begin
			write_unit(phase_units[p]);
			calm = (p == 3);
			count = 0;
			while (count < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 8) begin
					send_edge(1'b1, $urandom);
					count += 1;
				end else if (roll < 16) begin
					send_edge(1'b0, $urandom);
					send_pulse($urandom, pick_len(cur_unit));
					count += 3;
				end else if (roll < 20) begin
					send_pulse($urandom, pick_len(cur_unit));
					send_edge(1'b1, $urandom);
					count += 3;
				end else begin
					send_pulse($urandom, pick_len(cur_unit));
					count += 2;
				end
			end
		end
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			pop <= calm || ($urandom_range(99) >= 6);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
